>>> hw/rtl/grid_heat_diffusion_sweep_defines.svh
// assertion macros shared by the heat diffusion sweep rtl
`ifndef GRID_HEAT_DIFFUSION_SWEEP_DEFINES_SVH
`define GRID_HEAT_DIFFUSION_SWEEP_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define GHDS_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// condition holds in the cycle after the trigger
`define GHDS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

>>> hw/rtl/ghds_pkg.sv
// shared constants, types and command structs of the heat diffusion sweep
package ghds_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int WCFG_W     = 7;
  localparam int HCFG_W     = 16;
  localparam int DATA_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [1:0] TERM_LEFT  = 2'd0;
  localparam logic [1:0] TERM_RIGHT = 2'd1;
  localparam logic [1:0] TERM_UP    = 2'd2;
  localparam logic [1:0] TERM_DOWN  = 2'd3;

  typedef struct packed {
    logic           load;
    logic [X_W-1:0] rd_addr;
    logic           capture_cur;
    logic           capture_right;
    logic           acc_clr;
    logic           term_en;
    logic [1:0]     term_sel;
    logic           term_on;
    logic           acc_en;
    logic           scale;
    logic           absval;
    logic           round;
    logic           finish;
    logic           commit;
    logic           wr_a;
    logic [X_W-1:0] wr_addr;
    logic           last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/ghds_ram.sv
// generic single write port ram with registered read
module ghds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ghds_ctrl.sv
// sequencer: grid position, configuration registers and per cell step control
`include "grid_heat_diffusion_sweep_defines.svh"

module ghds_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ghds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ghds_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  input  logic                              in_kind,
  output logic                              in_ready,
  output ghds_pkg::cmd_t                    cmd,
  input  ghds_pkg::status_t                 sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_STORE = 4'd1;
  localparam logic [3:0] S_RD0   = 4'd2;
  localparam logic [3:0] S_RD1   = 4'd3;
  localparam logic [3:0] S_RD2   = 4'd4;
  localparam logic [3:0] S_TERM  = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_SCALE = 4'd7;
  localparam logic [3:0] S_ABS   = 4'd8;
  localparam logic [3:0] S_RND   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]                  state, state_next;
  logic [1:0]                  k;
  logic [ghds_pkg::X_W-1:0]    x;
  logic [ghds_pkg::HCFG_W-1:0] y;
  logic                        flush_phase;
  logic [ghds_pkg::WCFG_W-1:0] grid_width;
  logic [ghds_pkg::HCFG_W-1:0] grid_height;

  logic [ghds_pkg::WCFG_W-1:0] w_eff;
  logic [ghds_pkg::HCFG_W-1:0] h_eff;
  logic [ghds_pkg::WCFG_W-1:0] x_plus;
  logic                        row_end;
  logic                        grid_end;
  logic [3:0]                  mask;
  logic                        in_acc;
  logic                        advance;

  always_comb begin
    if (grid_width == '0) begin
      w_eff = ghds_pkg::WCFG_W'(1);
    end else if (grid_width > ghds_pkg::WCFG_W'(ghds_pkg::MAX_WIDTH)) begin
      w_eff = ghds_pkg::WCFG_W'(ghds_pkg::MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
  end

  assign h_eff    = (grid_height == '0) ? ghds_pkg::HCFG_W'(1) : grid_height;
  assign x_plus   = ghds_pkg::WCFG_W'(x) + ghds_pkg::WCFG_W'(1);
  assign row_end  = (x_plus == w_eff);
  assign grid_end = ({1'b0, y} + 17'd1) == {1'b0, h_eff};

  assign mask[ghds_pkg::TERM_LEFT]  = (x != '0);
  assign mask[ghds_pkg::TERM_RIGHT] = (x_plus < w_eff);
  assign mask[ghds_pkg::TERM_UP]    = flush_phase ? (h_eff != ghds_pkg::HCFG_W'(1))
                                                  : (y > ghds_pkg::HCFG_W'(1));
  assign mask[ghds_pkg::TERM_DOWN]  = !flush_phase;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign advance  = (state == S_STORE) || ((state == S_OUT) && sts.out_free);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (flush_phase) begin
            state_next = S_RD0;
          end else if (in_kind == ghds_pkg::KIND_CELL) begin
            state_next = (y == '0) ? S_STORE : S_RD0;
          end
        end
      end
      S_STORE: state_next = S_IDLE;
      S_RD0:   state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_TERM;
      S_TERM:  state_next = (k == 2'd3) ? S_ACC : S_TERM;
      S_ACC:   state_next = S_SCALE;
      S_SCALE: state_next = S_ABS;
      S_ABS:   state_next = S_RND;
      S_RND:   state_next = S_FIN;
      S_FIN:   state_next = S_OUT;
      S_OUT:   state_next = sts.out_free ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd               = '0;
    cmd.load          = in_acc;
    cmd.rd_addr       = (state == S_RD1) ? ghds_pkg::X_W'(x_plus) : x;
    cmd.capture_cur   = (state == S_RD1);
    cmd.capture_right = (state == S_RD2);
    cmd.acc_clr       = (state == S_RD2);
    cmd.term_en       = (state == S_TERM);
    cmd.term_sel      = k;
    cmd.term_on       = mask[k];
    cmd.acc_en        = ((state == S_TERM) && (k != 2'd0)) || (state == S_ACC);
    cmd.scale         = (state == S_SCALE);
    cmd.absval        = (state == S_ABS);
    cmd.round         = (state == S_RND);
    cmd.finish        = (state == S_FIN);
    cmd.commit        = (state == S_OUT) && sts.out_free;
    cmd.wr_a          = (state == S_STORE) || (cmd.commit && !flush_phase);
    cmd.wr_addr       = x;
    cmd.last          = flush_phase && row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      k           <= '0;
      x           <= '0;
      y           <= '0;
      flush_phase <= 1'b0;
      grid_width  <= ghds_pkg::WCFG_W'(64);
      grid_height <= ghds_pkg::HCFG_W'(64);
    end else begin
      state <= state_next;
      k     <= (state == S_TERM) ? k + 2'd1 : 2'd0;
      if (cfg_we) begin
        if (cfg_index == ghds_pkg::REG_GRID_WIDTH) begin
          grid_width <= cfg_data[ghds_pkg::WCFG_W-1:0];
        end else begin
          grid_height <= cfg_data;
        end
        x           <= '0;
        y           <= '0;
        flush_phase <= 1'b0;
      end else if (advance) begin
        if (row_end) begin
          x <= '0;
          if (flush_phase) begin
            flush_phase <= 1'b0;
            y           <= '0;
          end else if (grid_end) begin
            flush_phase <= 1'b1;
            y           <= '0;
          end else begin
            y <= y + ghds_pkg::HCFG_W'(1);
          end
        end else begin
          x <= ghds_pkg::X_W'(x_plus);
        end
      end
    end
  end

  `GHDS_ASSERT_NOW(a_commit_free, (state == S_OUT) && cmd.commit, sts.out_free,
    "result committed while output register still full")
  `GHDS_ASSERT_NOW(a_x_in_row, 1'b1, ghds_pkg::WCFG_W'(x) < w_eff,
    "column position beyond row width")
  `GHDS_ASSERT_NEXT(a_last_wraps, cmd.commit && cmd.last && !cfg_we,
    (x == '0) && !flush_phase && (y == '0), "grid did not restart after last result")
  `GHDS_ASSERT_NEXT(a_first_row_store, in_acc && !flush_phase && (y == '0) &&
    (in_kind == ghds_pkg::KIND_CELL), state == S_STORE, "first row cell not stored")

endmodule

>>> hw/rtl/ghds_dp.sv
// datapath: row stores, neighbour terms, scaling, rounding and output register
module ghds_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  ghds_pkg::cmd_t                      cmd,
  output ghds_pkg::status_t                   sts,
  input  logic [ghds_pkg::IN_TDATA_W-1:0]     in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ghds_pkg::DATA_W-1:0]         out_temp,
  output logic                                out_last
);

  logic [ghds_pkg::DATA_W-1:0] in_t, in_c, in_k;
  logic [ghds_pkg::DATA_W-1:0] t_cur, c_cur, cap_cur, upd_cur, acond_cur;
  logic [ghds_pkg::DATA_W-1:0] t_right, c_right;
  logic [ghds_pkg::DATA_W-1:0] left_t, left_c;
  logic [ghds_pkg::DATA_W-1:0] res;

  logic [3*ghds_pkg::DATA_W-1:0] a_rdata;
  logic [2*ghds_pkg::DATA_W-1:0] b_rdata;

  logic [ghds_pkg::DATA_W-1:0] tn, cn, m;
  logic signed [16:0]          d;
  logic signed [33:0]          prod_full;
  logic signed [32:0]          prod;
  logic signed [34:0]          acc;
  logic [16:0]                 f;
  logic signed [52:0]          scaled;
  logic                        neg;
  logic [51:0]                 mag;
  logic [52:0]                 rsum;
  logic [17:0]                 qm;
  logic signed [19:0]          qs, nt;

  ghds_ram #(.WIDTH(3 * ghds_pkg::DATA_W), .DEPTH(ghds_pkg::MAX_WIDTH)) u_row_a (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (cmd.wr_addr),
    .wdata ({in_k, in_c, in_t}),
    .raddr (cmd.rd_addr),
    .rdata (a_rdata)
  );

  ghds_ram #(.WIDTH(2 * ghds_pkg::DATA_W), .DEPTH(ghds_pkg::MAX_WIDTH)) u_row_b (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (cmd.wr_addr),
    .wdata ({c_cur, res}),
    .raddr (cmd.rd_addr),
    .rdata (b_rdata)
  );

  always_comb begin
    case (cmd.term_sel)
      ghds_pkg::TERM_LEFT:  begin tn = left_t;  cn = left_c;    end
      ghds_pkg::TERM_RIGHT: begin tn = t_right; cn = c_right;   end
      ghds_pkg::TERM_UP:    begin tn = upd_cur; cn = acond_cur; end
      default:              begin tn = in_t;    cn = in_c;      end
    endcase
  end

  assign m         = (cn < c_cur) ? cn : c_cur;
  assign d         = $signed({1'b0, tn}) - $signed({1'b0, t_cur});
  assign prod_full = d * $signed({1'b0, m});
  assign f         = 17'h10000 - {1'b0, cap_cur};
  assign rsum      = {1'b0, mag} + (53'd1 << 33);
  assign qs        = neg ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
  assign nt        = $signed({4'b0000, t_cur}) + qs;

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_t <= in_data[15:0];
      in_c <= in_data[31:16];
      in_k <= in_data[47:32];
    end
    if (cmd.capture_cur) begin
      t_cur     <= a_rdata[15:0];
      c_cur     <= a_rdata[31:16];
      cap_cur   <= a_rdata[47:32];
      upd_cur   <= b_rdata[15:0];
      acond_cur <= b_rdata[31:16];
    end
    if (cmd.capture_right) begin
      t_right <= a_rdata[15:0];
      c_right <= a_rdata[31:16];
    end
    if (cmd.term_en) begin
      prod <= cmd.term_on ? prod_full[32:0] : '0;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + {{2{prod[32]}}, prod};
    end
    if (cmd.scale) begin
      scaled <= acc * $signed({1'b0, f});
    end
    if (cmd.absval) begin
      neg <= scaled[52];
      mag <= scaled[52] ? 52'(-scaled) : 52'(scaled);
    end
    if (cmd.round) begin
      qm <= rsum[51:34];
    end
    if (cmd.finish) begin
      if (nt < 0) begin
        res <= '0;
      end else if (nt > 20'sd65535) begin
        res <= '1;
      end else begin
        res <= nt[15:0];
      end
    end
    if (cmd.commit) begin
      out_temp <= res;
      out_last <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      left_t    <= '0;
      left_c    <= '0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
        left_t    <= res;
        left_c    <= c_cur;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/grid_heat_diffusion_sweep.sv
// top level: four-neighbour heat diffusion sweep over a raster ordered grid
// flow: a cell of the second row on, or a flush, yields one result; a first row cell is
// only stored and yields nothing, and a flush while cells are due is ignored
// one request at a time, taken only once the last result is in the output register: two row
// reads, then the four neighbour terms one per cycle, then scaling, rounding and clamping
// reset: synchronous active high rst clears the sequencer, grid position and output valid,
// and sets grid_width and grid_height to 64; row stores hold stale data until rewritten
module grid_heat_diffusion_sweep (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [ghds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ghds_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // temperature [15:0], conductivity [31:16], heat_capacity [47:32]
  input  logic [ghds_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // kind [0]
  input  logic                                s_axis_tuser,
  // result requests
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // new_temperature [15:0]
  output logic [ghds_pkg::DATA_W-1:0]         m_axis_tdata,
  output logic                                m_axis_tlast
);

  // command and status between sequencer and datapath
  ghds_pkg::cmd_t    cmd;
  ghds_pkg::status_t sts;

  // sequencer owns the grid position and steps each cell through the datapath
  ghds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_kind   (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath holds the previous row, the left neighbour and the output register,
  // so a finished result can wait while the next request is taken
  ghds_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_temp  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

>>> sim/tb_grid_heat_diffusion_sweep.sv
// self-checking testbench of the raster-order heat diffusion sweep
module tb_grid_heat_diffusion_sweep;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;  // cycles with no request accepted on either side
  localparam int SETTLE     = 40;     // well above the result latency
  localparam int HOLD_LEN   = 400;    // long receiver hold-off

  typedef struct {
    logic        kind;
    logic [15:0] temp;
    logic [15:0] cond;
    logic [15:0] cap;
  } cell_req_t;

  typedef struct {
    logic [15:0] temp;
    logic        last;
  } heat_out_t;

  logic clk, rst;
  logic cfg_we;
  logic [ghds_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ghds_pkg::CFG_DATA_W-1:0] cfg_data;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [ghds_pkg::IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [ghds_pkg::DATA_W-1:0] m_axis_tdata;

  grid_heat_diffusion_sweep dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // mirror of the sweep state
  logic [6:0]  sw_width;
  logic [15:0] sw_height;
  logic [15:0] row_orig_t [ghds_pkg::MAX_WIDTH];
  logic [15:0] row_cond   [ghds_pkg::MAX_WIDTH];
  logic [15:0] row_cap    [ghds_pkg::MAX_WIDTH];
  logic [15:0] row_new_t  [ghds_pkg::MAX_WIDTH];
  logic [15:0] row_up_c   [ghds_pkg::MAX_WIDTH];
  logic [15:0] left_new_t, left_cond;
  int unsigned pos;

  cell_req_t pending_cells[$];
  heat_out_t expected_temps[$];

  int n_queued, n_accepted, n_results, n_errors, n_grids, quiet_cycles;
  int s_idle_pct, r_idle_pct;
  bit took_req;   // input request accepted at the last rising edge
  bit hold_req;   // ask the receiver for a long hold-off
  int hold_cnt;

  function automatic longint flow(logic [15:0] tn, logic [15:0] cn, logic [15:0] t,
                                  logic [15:0] c, logic [15:0] cap);
    longint d, m;
    d = longint'(tn) - longint'(t);
    m = (cn < c) ? longint'(cn) : longint'(c);
    return d * m * (longint'(65536) - longint'(cap));
  endfunction

  function automatic logic [15:0] relax_cell(int unsigned x, int unsigned y, int unsigned w,
                                             bit has_down, logic [15:0] dt, logic [15:0] dc);
    logic [15:0] t, c, k, res;
    longint s, q, nt;
    t = row_orig_t[x]; c = row_cond[x]; k = row_cap[x];
    s = 0;
    if (x > 0) s += flow(left_new_t, left_cond, t, c, k);
    if (x + 1 < w) s += flow(row_orig_t[x+1], row_cond[x+1], t, c, k);
    if (y > 0) s += flow(row_new_t[x], row_up_c[x], t, c, k);
    if (has_down) s += flow(dt, dc, t, c, k);
    // divide by four after the two 16-bit fractions (2^-34 in all) and round to an integer, ties away from zero
    if (s >= 0) q = (s + (longint'(1) <<< 33)) >>> 34;
    else q = -((-s + (longint'(1) <<< 33)) >>> 34);
    nt = longint'(t) + q;
    if (nt < 0) nt = 0;
    if (nt > 65535) nt = 65535;
    res = nt[15:0];
    row_new_t[x] = res; row_up_c[x] = c;
    left_new_t = res; left_cond = c;
    return res;
  endfunction

  // work out the result (if any) caused by one accepted request
  function automatic void sweep_step(cell_req_t r);
    int unsigned w, h, total, x;
    heat_out_t o;
    w = (sw_width == 0) ? 1 : (sw_width > ghds_pkg::MAX_WIDTH) ? ghds_pkg::MAX_WIDTH : sw_width;
    h = (sw_height == 0) ? 1 : sw_height;
    total = w * h;
    if (pos < total) begin
      if (r.kind == ghds_pkg::KIND_FLUSH) return;   // stray flush while cells are due
      x = pos % w;
      if (pos / w >= 1) begin
        o.temp = relax_cell(x, pos / w - 1, w, 1'b1, r.temp, r.cond);
        o.last = 1'b0;
        expected_temps.push_back(o);
      end
      row_orig_t[x] = r.temp; row_cond[x] = r.cond; row_cap[x] = r.cap;
      pos = (pos + 1) & 32'h3FFFFF;
    end else begin
      // drain phase: any request acts as a flush
      x = pos - total;
      if (x >= w) begin
        pos = 0;
        return;
      end
      o.temp = relax_cell(x, h - 1, w, 1'b0, 16'h0, 16'h0);
      o.last = (x + 1 == w);
      expected_temps.push_back(o);
      pos = o.last ? 0 : ((pos + 1) & 32'h3FFFFF);
    end
  endfunction

  // clock and watchdog
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // input acceptance: predict at the edge the request is taken
  always @(posedge clk) begin
    took_req = 1'b0;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      sweep_step('{kind: s_axis_tuser, temp: s_axis_tdata[15:0],
                   cond: s_axis_tdata[31:16], cap: s_axis_tdata[47:32]});
      n_accepted++;
      took_req = 1'b1;
    end
  end

  // request driver, changes on the falling edge
  always @(negedge clk) begin
    cell_req_t r;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || took_req) begin
      if (pending_cells.size() > 0 && $urandom_range(99) >= s_idle_pct) begin
        r = pending_cells.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {r.cap, r.cond, r.temp};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req || hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= (hold_cnt == 0) ? HOLD_LEN : hold_cnt - 1;
      if (hold_req && hold_cnt == 0) hold_req <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= r_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    heat_out_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (expected_temps.size() == 0) begin
        $display("%0t: unexpected result temp=%h last=%b", $time, m_axis_tdata, m_axis_tlast);
        n_errors++;
      end else begin
        e = expected_temps.pop_front();
        if (m_axis_tdata !== e.temp) begin
          $display("%0t: new_temperature expected %h actual %h", $time, e.temp, m_axis_tdata);
          n_errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $display("%0t: last expected %b actual %b", $time, e.last, m_axis_tlast);
          n_errors++;
        end
      end
    end
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void queue_req(logic kind, logic [15:0] t, logic [15:0] c, logic [15:0] k);
    pending_cells.push_back('{kind: kind, temp: t, cond: c, cap: k});
    n_queued++;
  endfunction

  // sender pause: wait for every request taken and every result back, then settle
  task automatic drain();
    while (n_accepted != n_queued || expected_temps.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [ghds_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ghds_pkg::REG_GRID_WIDTH) sw_width = val[6:0];
    else sw_height = val;
    pos = 0;
  endtask

  // one grid of cells plus its drain; rows_cut > 0 abandons it after that many rows
  task automatic queue_grid(int unsigned w, int unsigned h, int unsigned rows_cut);
    int unsigned rows;
    rows = (rows_cut > 0) ? rows_cut : h;
    for (int unsigned i = 0; i < w * rows; i++) begin
      if ($urandom_range(19) == 0) queue_req(ghds_pkg::KIND_FLUSH, pick16(), pick16(), pick16());
      queue_req(ghds_pkg::KIND_CELL, pick16(), pick16(), pick16());
    end
    if (rows_cut == 0)
      for (int unsigned i = 0; i < w; i++)
        // a cell during the drain acts as a flush
        queue_req(($urandom_range(4) == 0) ? ghds_pkg::KIND_CELL : ghds_pkg::KIND_FLUSH,
                  pick16(), pick16(), pick16());
    n_grids++;
  endtask

  initial begin
    int unsigned w, h, ew, eh, cut, goal;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    s_axis_tvalid = 1'b0; s_axis_tuser = 1'b0; s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    hold_req = 1'b0; hold_cnt = 0; took_req = 1'b0;
    n_queued = 0; n_accepted = 0; n_results = 0; n_errors = 0; n_grids = 0;
    quiet_cycles = 0;
    s_idle_pct = 0; r_idle_pct = 0;
    sw_width = 7'd64; sw_height = 16'd64; pos = 0;
    left_new_t = '0; left_cond = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: 3x2 grid with extreme fields, a stray flush mid-grid and a cell in the drain
    write_reg(ghds_pkg::REG_GRID_WIDTH, 16'd3);
    write_reg(ghds_pkg::REG_GRID_HEIGHT, 16'd2);
    queue_req(ghds_pkg::KIND_CELL, 16'hFFFF, 16'hFFFF, 16'h0000);
    queue_req(ghds_pkg::KIND_CELL, 16'h0000, 16'hFFFF, 16'h0000);
    queue_req(ghds_pkg::KIND_FLUSH, 16'h1234, 16'h5678, 16'h9ABC);
    queue_req(ghds_pkg::KIND_CELL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_req(ghds_pkg::KIND_CELL, 16'h0000, 16'h0000, 16'h0000);
    queue_req(ghds_pkg::KIND_CELL, 16'hFFFF, 16'h8000, 16'h8000);
    queue_req(ghds_pkg::KIND_CELL, 16'h0001, 16'hFFFF, 16'h0001);
    queue_req(ghds_pkg::KIND_FLUSH, 16'h0, 16'h0, 16'h0);
    queue_req(ghds_pkg::KIND_CELL, 16'hAAAA, 16'h5555, 16'hAAAA);
    queue_req(ghds_pkg::KIND_FLUSH, 16'h0, 16'h0, 16'h0);
    drain();
    // width and height out of range act as the nearest legal value
    write_reg(ghds_pkg::REG_GRID_WIDTH, 16'd0);
    write_reg(ghds_pkg::REG_GRID_HEIGHT, 16'd0);
    queue_req(ghds_pkg::KIND_CELL, 16'hFFFF, 16'hFFFF, 16'h0000);
    queue_req(ghds_pkg::KIND_FLUSH, 16'h0, 16'h0, 16'h0);
    drain();

    // random grids under three idling patterns
    for (int mode = 0; mode < 3; mode++) begin
      s_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 66 : 0;
      r_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 35 : 0;
      goal = n_queued + 330;
      if (mode != 1) hold_req = 1'b1;
      while (n_queued < goal) begin
        case ($urandom_range(9))
          0: w = 64;
          1: w = 127;
          2: w = 1;
          default: w = $urandom_range(2, 8);
        endcase
        cut = 0;
        case ($urandom_range(9))
          0: h = 1;
          1: h = 0;
          2: begin h = 65535; cut = $urandom_range(1, 3); end
          default: h = $urandom_range(2, 4);
        endcase
        if (w == 64 || w == 127) h = (h == 65535) ? h : $urandom_range(0, 2);
        ew = (w == 0) ? 1 : (w > ghds_pkg::MAX_WIDTH) ? ghds_pkg::MAX_WIDTH : w;
        eh = (h == 0) ? 1 : h;
        // sometimes keep the last setting and rely on the grid restarting by itself
        if (cut != 0 || $urandom_range(3) != 0 || n_grids < 3) begin
          write_reg(ghds_pkg::REG_GRID_WIDTH, w[15:0]);
          write_reg(ghds_pkg::REG_GRID_HEIGHT, h[15:0]);
        end else begin
          ew = (sw_width == 0) ? 1 :
               (sw_width > ghds_pkg::MAX_WIDTH) ? ghds_pkg::MAX_WIDTH : sw_width;
          eh = (sw_height == 0) ? 1 : sw_height;
          cut = (eh > 4) ? 2 : 0;
          if (cut != 0) begin
            // an abandoned tall grid must be restarted by a write
            write_reg(ghds_pkg::REG_GRID_HEIGHT, sw_height);
          end
        end
        queue_grid(ew, eh, cut);
        drain();
      end
    end

    drain();
    $display("covered %0d grids, %0d requests in, %0d results checked, %0d mismatches",
             n_grids, n_accepted, n_results, n_errors);
    $display("widths 1..64 incl. out of range codes, heights 0..65535, stalls and hold-offs");
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
